// ===== rtl/tesp_pkg.sv =====
// Shared types and constants for the terminal escape sequence parser.
`timescale 1ns / 1ps

package tesp_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned ACC_W             = 16;
  localparam int unsigned PARAM_IDX_W       = 4;
  localparam int unsigned PAYLOAD_LEN_W     = 11;
  localparam int unsigned RESULT_PARAMS_MAX = 16;
  localparam int unsigned CFG_ADDR_W        = 2;

  localparam logic [ACC_W-1:0] ACC_SAT = 16'hFFFF;

  // Control and delimiter bytes
  localparam logic [BYTE_W-1:0] CH_BEL       = 8'h07;
  localparam logic [BYTE_W-1:0] CH_CAN       = 8'h18;
  localparam logic [BYTE_W-1:0] CH_SUB       = 8'h1A;
  localparam logic [BYTE_W-1:0] CH_ESC       = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_DCS       = 8'h50;
  localparam logic [BYTE_W-1:0] CH_SOS       = 8'h58;
  localparam logic [BYTE_W-1:0] CH_CSI_INTRO = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_ST_FINAL  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_OSC_INTRO = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_PM        = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_APC       = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DEL       = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEMI      = 8'h3B;

  // Byte class bounds
  localparam logic [BYTE_W-1:0] CH_INTER_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_INTER_HI  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DIGIT_LO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT_HI  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_PRIV_LO   = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_PARAM_HI  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_FINAL_LO  = 8'h40;
  localparam logic [BYTE_W-1:0] CH_FINAL_HI  = 8'h7E;

  typedef enum logic [2:0] {
    MODE_GROUND,
    MODE_ESCAPE,
    MODE_CSI,
    MODE_OSC,
    MODE_IGNORE
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_ESC_DISPATCH,
    EV_CSI_PARAM,
    EV_OSC_BYTE,
    EV_OSC_END
  } event_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CSI_ENABLE,
    CFG_ESC_ENABLE,
    CFG_OSC_ENABLE
  } cfg_reg_e;

  typedef enum logic {
    ST_PARSE,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic                     handled;
    event_e                   event_kind;
    logic [BYTE_W-1:0]        final_byte;
    logic [BYTE_W-1:0]        marker_byte;
    logic [PARAM_IDX_W-1:0]   param_index;
    logic [ACC_W-1:0]         param_value;
    logic [BYTE_W-1:0]        payload_byte;
    logic [PAYLOAD_LEN_W-1:0] payload_length;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic step;        // parse the input byte, load its single result
    logic start_emit;  // CSI final: store last parameter, arm emission
    logic emit;        // load the next parameter result
    logic finish;      // last parameter emitted, clear the sequence
  } cmd_t;

  typedef struct packed {
    logic csi_dispatch;  // input byte closes a CSI sequence that dispatches
    logic emit_last;     // current parameter is the final one to emit
  } stat_t;

endpackage

// ===== rtl/tesp_if.sv =====
// Channel interfaces: input bytes, parser results and configuration writes.
`timescale 1ns / 1ps

interface tesp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [tesp_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tesp_result_if;
  logic                              valid;
  logic                              ready;
  logic                              handled;
  logic [2:0]                        event_kind;
  logic [tesp_pkg::BYTE_W-1:0]        final_byte;
  logic [tesp_pkg::BYTE_W-1:0]        marker_byte;
  logic [tesp_pkg::PARAM_IDX_W-1:0]   param_index;
  logic [tesp_pkg::ACC_W-1:0]         param_value;
  logic [tesp_pkg::BYTE_W-1:0]        payload_byte;
  logic [tesp_pkg::PAYLOAD_LEN_W-1:0] payload_length;
  logic                              last;

  modport source (
    output valid, output handled, output event_kind, output final_byte,
    output marker_byte, output param_index, output param_value,
    output payload_byte, output payload_length, output last, input ready
  );
  modport sink (
    input valid, input handled, input event_kind, input final_byte,
    input marker_byte, input param_index, input param_value,
    input payload_byte, input payload_length, input last, output ready
  );
endinterface

interface tesp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tesp_pkg::CFG_ADDR_W-1:0] index;
  logic                           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tesp_datapath.sv =====
// Parser datapath: sequence state, parameter store, config and result register.
`timescale 1ns / 1ps

module tesp_datapath #(
  parameter int unsigned MAX_PARAMS = 16,
  parameter int unsigned BUF_DEPTH  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tesp_pkg::BYTE_W-1:0]          in_byte_i,
  input  logic                                cfg_we_i,
  input  logic [tesp_pkg::CFG_ADDR_W-1:0]      cfg_idx_i,
  input  logic                                cfg_data_i,
  input  tesp_pkg::cmd_t                      cmd_i,
  output tesp_pkg::stat_t                     stat_o,
  output tesp_pkg::result_t                   res_o
);
  import tesp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int unsigned PCNT_W = $clog2(MAX_PARAMS + 1);
  localparam int unsigned PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  mode_e                  mode_q, mode_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [PCNT_W-1:0]      pcnt_q, pcnt_d;
  logic [BYTE_W-1:0]      pmark_q, pmark_d;
  logic [BYTE_W-1:0]      inter_q, inter_d;
  logic                   err_q, err_d;
  logic [PARAM_IDX_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0]      fin_q, fin_d;
  result_t                res_q, res_d;
  logic                   csi_en_q, esc_en_q, osc_en_q;

  logic [ACC_W-1:0]       store_q [MAX_PARAMS];
  logic                   st_we;

  logic [BYTE_W-1:0]      b;
  logic                   is_abort;
  logic                   buf_room;
  logic                   param_room;
  logic                   is_final;
  logic [19:0]            acc_x10;
  logic [ACC_W-1:0]       acc_sat;
  logic [PCNT_W:0]        idx_nxt;
  logic                   clr;
  result_t                step_res;

  assign b          = in_byte_i;
  assign is_abort   = (b == CH_ESC) || (b == CH_CAN) || (b == CH_SUB);
  assign buf_room   = cnt_q < CNT_W'(BUF_DEPTH);
  assign param_room = pcnt_q < PCNT_W'(MAX_PARAMS);
  assign is_final   = (b >= CH_FINAL_LO) && (b <= CH_FINAL_HI);

  // acc * 10 + digit as two shifted adds
  assign acc_x10 = (20'(acc_q) << 3) + (20'(acc_q) << 1) + 20'(b[3:0]);
  assign acc_sat = (acc_x10 > 20'(ACC_SAT)) ? ACC_SAT : acc_x10[ACC_W-1:0];

  // Parameter emission stops at the store count or at the per-byte result cap
  assign idx_nxt = (PCNT_W + 1)'(idx_q) + 1'b1;
  assign stat_o.emit_last = (idx_nxt == {1'b0, pcnt_q}) ||
                            (idx_q == PARAM_IDX_W'(RESULT_PARAMS_MAX - 1));
  assign stat_o.csi_dispatch = (mode_q == MODE_CSI) && is_final && csi_en_q &&
                               !err_q && param_room;

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    pcnt_d   = pcnt_q;
    pmark_d  = pmark_q;
    inter_d  = inter_q;
    err_d    = err_q;
    idx_d    = idx_q;
    fin_d    = fin_q;
    res_d    = res_q;
    st_we    = 1'b0;
    clr      = 1'b0;
    step_res            = '0;
    step_res.handled    = 1'b1;
    step_res.event_kind = EV_NONE;
    step_res.last       = 1'b1;

    if (cmd_i.step) begin
      if (is_abort) begin
        clr    = 1'b1;
        mode_d = (b == CH_ESC) ? MODE_ESCAPE : MODE_GROUND;
      end else begin
        case (mode_q)
          MODE_ESCAPE: begin
            if (b == CH_CSI_INTRO) begin
              clr    = 1'b1;
              mode_d = MODE_CSI;
            end else if (b == CH_OSC_INTRO) begin
              clr    = 1'b1;
              mode_d = MODE_OSC;
            end else if (b == CH_DCS || b == CH_SOS || b == CH_PM || b == CH_APC) begin
              mode_d = MODE_IGNORE;
            end else if (b == CH_ST_FINAL) begin
              clr    = 1'b1;
              mode_d = MODE_GROUND;
            end else if (b >= CH_INTER_LO && b <= CH_INTER_HI) begin
              if (buf_room) begin
                cnt_d = cnt_q + 1'b1;
                if (inter_q == '0) inter_d = b;
                else err_d = 1'b1;
              end
            end else if (b >= CH_DIGIT_LO && b <= CH_FINAL_HI) begin
              if (!err_q && esc_en_q) begin
                step_res.event_kind  = EV_ESC_DISPATCH;
                step_res.final_byte  = b;
                step_res.marker_byte = inter_q;
              end
              clr    = 1'b1;
              mode_d = MODE_GROUND;
            end else begin
              step_res.handled = 1'b0;
            end
          end
          MODE_CSI: begin
            if (is_final) begin
              // only the non-dispatching close lands here
              clr    = 1'b1;
              mode_d = MODE_GROUND;
            end else if (b == CH_DEL) begin
              mode_d = MODE_CSI;
            end else if (b >= CH_INTER_LO && b <= CH_PARAM_HI) begin
              if (buf_room) begin
                cnt_d = cnt_q + 1'b1;
                if (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) begin
                  acc_d = acc_sat;
                end else if (b == CH_SEMI) begin
                  if (param_room) begin
                    st_we  = 1'b1;
                    pcnt_d = pcnt_q + 1'b1;
                  end else begin
                    err_d = 1'b1;
                  end
                  acc_d = '0;
                end else if (b >= CH_PRIV_LO) begin
                  if (pmark_q == '0) pmark_d = b;
                  else err_d = 1'b1;
                end else if (b <= CH_INTER_HI) begin
                  if (inter_q == '0) inter_d = b;
                  else err_d = 1'b1;
                end else if (b == CH_COLON) begin
                  err_d = 1'b1;
                end
              end
            end else begin
              step_res.handled = 1'b0;
            end
          end
          MODE_OSC: begin
            if (b == CH_BEL) begin
              clr    = 1'b1;
              mode_d = MODE_GROUND;
            end else if (b >= CH_INTER_LO) begin
              if (buf_room) begin
                cnt_d = cnt_q + 1'b1;
                if (osc_en_q) begin
                  step_res.event_kind   = EV_OSC_BYTE;
                  step_res.payload_byte = b;
                end
              end
            end
          end
          MODE_IGNORE: begin
            mode_d = MODE_IGNORE;
          end
          default: begin
            mode_d           = MODE_GROUND;
            step_res.handled = 1'b0;
          end
        endcase
      end

      if (clr) begin
        // leaving an OSC string reports its length first
        if (mode_q == MODE_OSC && osc_en_q) begin
          step_res.event_kind     = EV_OSC_END;
          step_res.payload_length = PAYLOAD_LEN_W'(cnt_q);
        end
        cnt_d   = '0;
        acc_d   = '0;
        pcnt_d  = '0;
        pmark_d = '0;
        inter_d = '0;
        err_d   = 1'b0;
      end
      res_d = step_res;
    end else if (cmd_i.start_emit) begin
      st_we  = 1'b1;
      pcnt_d = pcnt_q + 1'b1;
      acc_d  = '0;
      mode_d = MODE_GROUND;
      idx_d  = '0;
      fin_d  = b;
    end else if (cmd_i.emit) begin
      res_d.handled        = 1'b1;
      res_d.event_kind     = EV_CSI_PARAM;
      res_d.final_byte     = fin_q;
      res_d.marker_byte    = pmark_q;
      res_d.param_index    = idx_q;
      res_d.param_value    = store_q[PIDX_W'(idx_q)];
      res_d.payload_byte   = '0;
      res_d.payload_length = '0;
      res_d.last           = stat_o.emit_last;
      idx_d                = idx_q + 1'b1;
      if (cmd_i.finish) begin
        cnt_d   = '0;
        acc_d   = '0;
        pcnt_d  = '0;
        pmark_d = '0;
        inter_d = '0;
        err_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_GROUND;
      cnt_q    <= '0;
      acc_q    <= '0;
      pcnt_q   <= '0;
      pmark_q  <= '0;
      inter_q  <= '0;
      err_q    <= 1'b0;
      idx_q    <= '0;
      csi_en_q <= 1'b1;
      esc_en_q <= 1'b1;
      osc_en_q <= 1'b1;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      pcnt_q  <= pcnt_d;
      pmark_q <= pmark_d;
      inter_q <= inter_d;
      err_q   <= err_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CSI_ENABLE: csi_en_q <= cfg_data_i;
          CFG_ESC_ENABLE: esc_en_q <= cfg_data_i;
          CFG_OSC_ENABLE: osc_en_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    res_q <= res_d;
    if (st_we) begin
      store_q[PIDX_W'(pcnt_q)] <= acc_q;
    end
  end

  assign res_o = res_q;

  a_pcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= PCNT_W'(MAX_PARAMS))
    else $error("parameter count above MAX_PARAMS");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(BUF_DEPTH))
    else $error("collected count above BUF_DEPTH");

  a_emit_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> ((PCNT_W + 1)'(idx_q) < {1'b0, pcnt_q}))
    else $error("parameter emitted beyond stored count");

endmodule

// ===== rtl/tesp_ctrl.sv =====
// Parser controller: input handshake, result register valid and parameter emission.
`timescale 1ns / 1ps

module tesp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  tesp_pkg::stat_t stat_i,
  output tesp_pkg::cmd_t  cmd_o
);
  import tesp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  // result register can take a new transaction this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_PARSE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          if (stat_i.csi_dispatch) begin
            cmd_o.start_emit = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            cmd_o.step  = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_PARSE;
          end
        end
      end
      default: begin
        state_d = ST_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(cmd_o.step || cmd_o.emit))
    else $error("result register overwritten while stalled");

  a_accept_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (cmd_o.step || cmd_o.start_emit))
    else $error("accepted byte not processed");

  a_emit_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_emit |=> (state_q == ST_EMIT && !in_ready_o))
    else $error("emission did not follow CSI dispatch");

endmodule

// ===== rtl/terminal_escape_sequence_parser_top.sv =====
// Top level of the terminal escape sequence parser.
`timescale 1ns / 1ps

// Usage:
//   in_i  carries one terminal byte per transaction (valid/ready).
//   res_o carries results; each byte yields one or more results, the final
//         one of a byte flagged by last.
//   cfg_i writes the enable registers (index 0 CSI, 1 ESC, 2 OSC); it is
//         always ready and should only be written while the parser is idle.
// Timing:
//   Except for a dispatching CSI final byte, a result is registered when
//   its byte is accepted and appears in the output register the cycle
//   after. A dispatching CSI final byte has an accept step that stores
//   the last parameter; then each stored parameter, up to 16, is read
//   out of the parameter register file into the output register. Outside
//   emission, a new byte is accepted in the same cycle a result is taken.
// Reset:
//   rst_ni clears the parser to ground mode with all enables set; the
//   parameter register file is not cleared and holds no valid entries.
// Stall:
//   While a result is pending and res_o is not ready, the output register
//   holds, in_i.ready drops and parsing pauses without losing state.

module terminal_escape_sequence_parser_top #(
  parameter int unsigned MAX_PARAMS = 16,
  parameter int unsigned BUF_DEPTH  = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tesp_byte_if.sink      in_i,
  tesp_result_if.source  res_o,
  tesp_cfg_if.sink       cfg_i
);
  import tesp_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  tesp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tesp_datapath #(
    .MAX_PARAMS (MAX_PARAMS),
    .BUF_DEPTH  (BUF_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_i.in_byte),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res)
  );

  assign res_o.handled        = res.handled;
  assign res_o.event_kind     = res.event_kind;
  assign res_o.final_byte     = res.final_byte;
  assign res_o.marker_byte    = res.marker_byte;
  assign res_o.param_index    = res.param_index;
  assign res_o.param_value    = res.param_value;
  assign res_o.payload_byte   = res.payload_byte;
  assign res_o.payload_length = res.payload_length;
  assign res_o.last           = res.last;

endmodule
